@@ rtl/assert_macros.svh @@
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

@@ rtl/pitg_pkg.sv @@
// Package with constants, codes and types of the triangle index generator.
`timescale 1ns / 1ps

package pitg_pkg;

   localparam int INDEX_BITS       = 16;
   localparam int MAX_TESSELLATION = 180;
   localparam int OUT_BITS         = 16;
   // Indices wrap at the narrower of the internal index width and the output width.
   localparam int IDX_W = (INDEX_BITS < OUT_BITS) ? INDEX_BITS : OUT_BITS;

   localparam int ROW_BITS      = 8;
   localparam int COL_BITS      = 9;
   localparam int TESS_BITS     = 8;
   localparam int STRIDE_BITS   = 9;
   localparam int MODE_BITS     = 3;
   localparam int BASE_BITS     = 16;
   localparam int CSR_DATA_BITS = 16;
   localparam int CSR_IDX_BITS  = 2;

   localparam int REQ_DATA_BITS = 24;
   localparam int RSP_DATA_BITS = 6 * OUT_BITS;
   localparam int RSP_USER_BITS = 2;

   localparam logic [TESS_BITS-1:0] TESS_MIN   = 8'd3;
   localparam logic [TESS_BITS-1:0] TESS_MAX   = TESS_BITS'(MAX_TESSELLATION);
   localparam logic [TESS_BITS-1:0] TESS_RESET = 8'd3;

   localparam logic [MODE_BITS-1:0] MODE_SPHERE = 3'd0;
   localparam logic [MODE_BITS-1:0] MODE_TORUS  = 3'd1;
   localparam logic [MODE_BITS-1:0] MODE_CONE   = 3'd2;
   localparam logic [MODE_BITS-1:0] MODE_BOTTOM = 3'd3;
   localparam logic [MODE_BITS-1:0] MODE_TOP    = 3'd4;

   localparam logic [CSR_IDX_BITS-1:0] CSR_SHAPE_MODE   = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TESSELLATION = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RIGHT_HANDED = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CAP_BASE     = 2'd3;

   // Live configuration with the strides that follow from the tessellation.
   typedef struct packed {
      logic [MODE_BITS-1:0]   shape_mode;
      logic [TESS_BITS-1:0]   tess;           // clamped segment count t
      logic [STRIDE_BITS-1:0] sphere_stride;  // 2t+1
      logic [STRIDE_BITS-1:0] ring_stride;    // t+1
      logic [STRIDE_BITS-1:0] cone_wrap;      // 2t+2
      logic                   right_handed;
      logic [BASE_BITS-1:0]   cap_base;
   } cfg_type;

endpackage

@@ rtl/primitive_triangle_index_generator.sv @@
// Top level: three-stage pipeline that turns grid positions into triangle indices.
// One beat carries a row and column position and returns one beat with up to two
// triangles of 16-bit vertex indices; a new position is taken every cycle while the
// result side does not stall. A beat passes through the three register stages (bounds
// check and wrap, stride multiply, corner add and select) before it is on the result
// ports. A stall on the result side holds the pipeline stage by stage, and empty stages
// keep taking beats.
// Configuration writes take effect on the next cycle; the user must make them only while
// no beat is in flight, as the block itself does not enforce this.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module primitive_triangle_index_generator (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // row [7:0], column [16:8], zero pad [23:17]
   input  logic [pitg_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // first_a, first_b, first_c, second_a, second_b, second_c (16 bits each)
   output logic [pitg_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   // second_valid [0], in_range [1]
   output logic [pitg_pkg::RSP_USER_BITS-1:0]   rsp_tuser,
   input  logic                                 csr_we,
   input  logic [pitg_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [pitg_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import pitg_pkg::*;

   typedef struct packed {
      logic [IDX_W-1:0] c;
      logic [IDX_W-1:0] b;
      logic [IDX_W-1:0] a;
   } tri_type;

   cfg_type cfg;

   pitg_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   logic rdy1, rdy2, rdy3;

   // Stage 1: bounds check and wrapped neighbors
   logic                   s1_valid_ff, s1_valid_in;
   logic [ROW_BITS-1:0]    s1_row_ff, s1_row_in;
   logic [COL_BITS-1:0]    s1_col_ff, s1_col_in;
   logic [COL_BITS-1:0]    s1_next_col_ff, s1_next_col_in;
   logic [STRIDE_BITS-1:0] s1_next_row_ff, s1_next_row_in;
   logic [STRIDE_BITS-1:0] s1_stride_ff, s1_stride_in;
   logic                   s1_in_range_ff, s1_in_range_in;

   // Stage 2: row base products and single-triangle corners
   logic                   s2_valid_ff, s2_valid_in;
   logic [COL_BITS-1:0]    s2_col_ff;
   logic [COL_BITS-1:0]    s2_next_col_ff;
   logic [IDX_W-1:0]       s2_base0_ff, s2_base0_in;
   logic [IDX_W-1:0]       s2_base1_ff, s2_base1_in;
   logic                   s2_in_range_ff;
   tri_type                s2_single_ff, s2_single_in;

   // Stage 3: output register
   logic                   s3_valid_ff, s3_valid_in;
   tri_type                s3_first_ff, s3_first_in;
   tri_type                s3_second_ff, s3_second_in;
   logic                   s3_second_valid_ff, s3_second_valid_in;
   logic                   s3_in_range_ff, s3_in_range_in;

   // A stage takes a new beat when it is empty or its successor takes its beat.
   assign rdy3       = !s3_valid_ff || rsp_tready;
   assign rdy2       = !s2_valid_ff || rdy3;
   assign rdy1       = !s1_valid_ff || rdy2;
   assign req_tready = rdy1;

   // ---------------- stage 1 ----------------
   logic [COL_BITS:0]      c_inc;
   logic [STRIDE_BITS-1:0] r_inc;

   always_comb begin
      s1_row_in      = req_tdata[ROW_BITS-1:0];
      s1_col_in      = req_tdata[ROW_BITS +: COL_BITS];
      r_inc          = {1'b0, s1_row_in} + 9'd1;
      c_inc          = {1'b0, s1_col_in} + 10'd1;
      s1_stride_in   = '0;
      s1_next_col_in = c_inc[COL_BITS-1:0];
      s1_next_row_in = r_inc;
      s1_in_range_in = 1'b0;
      case (cfg.shape_mode)
         MODE_SPHERE: begin
            s1_stride_in   = cfg.sphere_stride;
            s1_in_range_in = (s1_row_in < cfg.tess) && (s1_col_in < cfg.sphere_stride);
            if (c_inc == {1'b0, cfg.sphere_stride}) s1_next_col_in = '0;
         end
         MODE_TORUS: begin
            s1_stride_in   = cfg.ring_stride;
            s1_in_range_in = (s1_row_in <= cfg.tess) && (s1_col_in <= {1'b0, cfg.tess});
            if (c_inc == {1'b0, cfg.ring_stride}) s1_next_col_in = '0;
            if (r_inc == cfg.ring_stride) s1_next_row_in = '0;
         end
         MODE_CONE: begin
            s1_in_range_in = s1_col_in <= {1'b0, cfg.tess};
         end
         MODE_BOTTOM, MODE_TOP: begin
            s1_in_range_in = s1_col_in < ({1'b0, cfg.tess} - 9'd2);
         end
         default: s1_in_range_in = 1'b0;
      endcase
      s1_valid_in = rdy1 ? req_tvalid : s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (rdy1) begin
         s1_row_ff      <= s1_row_in;
         s1_col_ff      <= s1_col_in;
         s1_next_col_ff <= s1_next_col_in;
         s1_next_row_ff <= s1_next_row_in;
         s1_stride_ff   <= s1_stride_in;
         s1_in_range_ff <= s1_in_range_in;
      end
   end

   // ---------------- stage 2 ----------------
   logic [COL_BITS:0]   two_c;
   logic [COL_BITS+1:0] cone_b, cone_c, cone_w;
   logic [IDX_W-1:0]    cap_p, cap_q;

   always_comb begin
      s2_base0_in = IDX_W'(s1_row_ff) * IDX_W'(s1_stride_ff);
      s2_base1_in = IDX_W'(s1_next_row_ff) * IDX_W'(s1_stride_ff);

      two_c  = {s1_col_ff, 1'b0};
      cone_w = {2'b00, cfg.cone_wrap};
      cone_b = {1'b0, two_c} + 11'd3;
      cone_c = {1'b0, two_c} + 11'd1;
      // For an in-range column, 2c+3 and 2c+1 stay below twice the wrap, so one subtract suffices.
      if (cone_b >= cone_w) cone_b = cone_b - cone_w;
      if (cone_c >= cone_w) cone_c = cone_c - cone_w;

      cap_p = IDX_W'(cfg.cap_base) + IDX_W'(s1_col_ff) + IDX_W'(1);
      cap_q = IDX_W'(cfg.cap_base) + IDX_W'(s1_col_ff) + IDX_W'(2);

      s2_single_in = '0;
      case (cfg.shape_mode)
         MODE_CONE: begin
            s2_single_in.a = IDX_W'(two_c);
            s2_single_in.b = IDX_W'(cone_b);
            s2_single_in.c = IDX_W'(cone_c);
         end
         MODE_BOTTOM: begin
            s2_single_in.a = IDX_W'(cfg.cap_base);
            s2_single_in.b = cap_p;
            s2_single_in.c = cap_q;
         end
         MODE_TOP: begin
            s2_single_in.a = IDX_W'(cfg.cap_base);
            s2_single_in.b = cap_q;
            s2_single_in.c = cap_p;
         end
         default: s2_single_in = '0;
      endcase
      s2_valid_in = rdy2 ? s1_valid_ff : s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
      if (rdy2) begin
         s2_col_ff      <= s1_col_ff;
         s2_next_col_ff <= s1_next_col_ff;
         s2_base0_ff    <= s2_base0_in;
         s2_base1_ff    <= s2_base1_in;
         s2_in_range_ff <= s1_in_range_ff;
         s2_single_ff   <= s2_single_in;
      end
   end

   // ---------------- stage 3 ----------------
   logic [IDX_W-1:0] r0c, r0n, r1c, r1n;
   tri_type          first_raw, second_raw;
   logic             two_tris;

   function automatic tri_type orient(tri_type t, logic keep);
      tri_type res;
      res = t;
      if (!keep) begin
         res.a = t.c;
         res.c = t.a;
      end
      return res;
   endfunction

   always_comb begin
      r0c = s2_base0_ff + IDX_W'(s2_col_ff);
      r0n = s2_base0_ff + IDX_W'(s2_next_col_ff);
      r1c = s2_base1_ff + IDX_W'(s2_col_ff);
      r1n = s2_base1_ff + IDX_W'(s2_next_col_ff);
      first_raw  = '0;
      second_raw = '0;
      two_tris   = 1'b0;
      case (cfg.shape_mode)
         MODE_SPHERE: begin
            first_raw  = '{c: r0n, b: r1c, a: r0c};
            second_raw = '{c: r1n, b: r1c, a: r0n};
            two_tris   = 1'b1;
         end
         MODE_TORUS: begin
            first_raw  = '{c: r1c, b: r0n, a: r0c};
            second_raw = '{c: r1c, b: r1n, a: r0n};
            two_tris   = 1'b1;
         end
         MODE_CONE, MODE_BOTTOM, MODE_TOP: begin
            first_raw = s2_single_ff;
         end
         default: two_tris = 1'b0;
      endcase

      s3_in_range_in     = s2_in_range_ff;
      s3_second_valid_in = s2_in_range_ff && two_tris;
      s3_first_in        = s2_in_range_ff ? orient(first_raw, cfg.right_handed) : '0;
      s3_second_in       = s3_second_valid_in ? orient(second_raw, cfg.right_handed) : '0;
      s3_valid_in        = rdy3 ? s2_valid_ff : s3_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s3_valid_in;
      end
      if (rdy3) begin
         s3_first_ff        <= s3_first_in;
         s3_second_ff       <= s3_second_in;
         s3_second_valid_ff <= s3_second_valid_in;
         s3_in_range_ff     <= s3_in_range_in;
      end
   end

   assign rsp_tvalid = s3_valid_ff;
   assign rsp_tdata  = {OUT_BITS'(s3_second_ff.c), OUT_BITS'(s3_second_ff.b),
                        OUT_BITS'(s3_second_ff.a), OUT_BITS'(s3_first_ff.c),
                        OUT_BITS'(s3_first_ff.b),  OUT_BITS'(s3_first_ff.a)};
   assign rsp_tuser  = {s3_in_range_ff, s3_second_valid_ff};

   // ---------------- assertions ----------------
   `ASSERT_CLK(a_out_of_range_zero,
      (rsp_tvalid && !rsp_tuser[1]) |-> (rsp_tdata == '0),
      "out of range beat carries nonzero indices")
   `ASSERT_CLK(a_second_needs_range,
      (rsp_tvalid && rsp_tuser[0]) |-> rsp_tuser[1],
      "second triangle flagged outside range")
   `ASSERT_CLK(a_no_second_zero,
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata[RSP_DATA_BITS-1:3*OUT_BITS] == '0),
      "absent second triangle is not zero")
   `ASSERT_CLK(a_stage1_holds,
      (s1_valid_ff && !rdy2) |=> (s1_valid_ff && $stable(s1_col_ff) && $stable(s1_row_ff)),
      "stage one beat lost during stall")

endmodule

@@ rtl/pitg_cfg_regs.sv @@
// Configuration registers with tessellation clamp and derived strides.
`timescale 1ns / 1ps

module pitg_cfg_regs (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [pitg_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [pitg_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output pitg_pkg::cfg_type                    cfg
);
   import pitg_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic [TESS_BITS-1:0] tess_clamped;

   function automatic cfg_type set_tess(cfg_type cur, logic [TESS_BITS-1:0] t);
      cfg_type res;
      res               = cur;
      res.tess          = t;
      res.sphere_stride = {t, 1'b0} + 9'd1;
      res.ring_stride   = {1'b0, t} + 9'd1;
      res.cone_wrap     = {t, 1'b0} + 9'd2;
      return res;
   endfunction

   function automatic cfg_type reset_cfg();
      cfg_type res;
      res              = set_tess('0, TESS_RESET);
      res.shape_mode   = MODE_SPHERE;
      res.right_handed = 1'b1;
      res.cap_base     = '0;
      return res;
   endfunction

   always_comb begin
      if (csr_wdata[TESS_BITS-1:0] < TESS_MIN) begin
         tess_clamped = TESS_MIN;
      end else if (csr_wdata[TESS_BITS-1:0] > TESS_MAX) begin
         tess_clamped = TESS_MAX;
      end else begin
         tess_clamped = csr_wdata[TESS_BITS-1:0];
      end

      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SHAPE_MODE:   cfg_in.shape_mode   = csr_wdata[MODE_BITS-1:0];
            CSR_TESSELLATION: cfg_in              = set_tess(cfg_ff, tess_clamped);
            CSR_RIGHT_HANDED: cfg_in.right_handed = csr_wdata[0];
            CSR_CAP_BASE:     cfg_in.cap_base     = csr_wdata[BASE_BITS-1:0];
            default:          cfg_in              = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= reset_cfg();
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
